// File: rtl/core/nafd_pkg.sv
`default_nettype none

package nafd_pkg;

  localparam int CHIP_COUNT        = 2;
  localparam int CHANNELS_PER_CHIP = 32;
  localparam int TOTAL_CH          = CHIP_COUNT * CHANNELS_PER_CHIP;

  localparam int POS_STAMP_LO = 4;
  localparam int POS_STAMP_HI = 5;
  localparam int POS_ACC      = 9;
  localparam int POS_AMP0     = 12;
  localparam int POS_DIGITAL  = TOTAL_CH + 22;
  localparam int POS_LAST     = TOTAL_CH + 23;
  localparam int POS_W        = $clog2(POS_LAST + 1);

  localparam int CHIP_W = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;
  localparam int CHAN_W = (CHANNELS_PER_CHIP > 1) ? $clog2(CHANNELS_PER_CHIP) : 1;

  localparam int WORD_W     = 16;
  localparam int CHAN_IDX_W = 6;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 184;

  localparam logic [WORD_W-1:0] ACC_WORD_RST = 16'h8000;
  localparam logic [WORD_W-1:0] AMP_GAIN_RST = 16'd12780;
  localparam logic [WORD_W-1:0] ACC_GAIN_RST = 16'd627;

  localparam logic [1:0] PHASE_NONE  = 2'd0;
  localparam logic [1:0] PHASE_FIRST = 2'd1;
  localparam logic [1:0] PHASE_LAST  = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_PHASE = 2'd0,
    CFG_AMP_GAIN    = 2'd1,
    CFG_ACC_GAIN    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_SUMMARY = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] amp_gain;
    logic [WORD_W-1:0] acc_gain;
  } gains_t;

  typedef struct packed {
    item_kind_t            kind;
    logic [CHAN_IDX_W-1:0] chan;
    logic [WORD_W-1:0]     word;
    logic [VAL_W-1:0]      stamp;
    logic [WORD_W-1:0]     digital;
    logic [WORD_W-1:0]     acc0;
    logic [WORD_W-1:0]     acc1;
    logic [WORD_W-1:0]     acc2;
    logic                  done;
  } stg_t;

endpackage

`default_nettype wire

// File: rtl/core/neural_amp_frame_deframer.sv
// Neural amplifier frame deframer.
// in_*: one 16-bit frame word per transfer; frames are 24 words plus one word
// per amplifier channel (88 words for two chips of 32 channels).
// out_*: one result per amplifier word (tuser 0: channel index and scaled
// sample) and one frame summary on the last word (tuser 1: timestamp,
// digital inputs and, when a triplet completed, the scaled accelerometer).
// Header, accelerometer, timestamp and digital words give no result.
// cfg_*: write start_phase, amp_gain, acc_gain by index, only while idle.
// Throughput: one word per cycle, sustained, with out_tready held high.
// Pipeline: the word enters the stage register when it transfers, and the
// product logic then loads the output register from it; out_tvalid rises
// when the output register is loaded, and the result transfers from there.
// Reset: frame position to word 0, phase 0, gains to their defaults,
// accelerometer words to mid-scale; both pipeline registers empty.
// Stall: with out_tready low the output register holds; the stage register
// still takes one word, and in_tready drops only when both are full.
`default_nettype none

module neural_amp_frame_deframer import nafd_pkg::*; (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire  [CFG_IDX_W-1:0]    cfg_index,
  input  wire  [CFG_DATA_W-1:0]   cfg_data,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire  [WORD_W-1:0]       in_tdata,    // frame_word
  output logic                    out_tvalid,
  input  wire                     out_tready,
  // channel_index, amp_value, time_stamp, digital_inputs, acc_first,
  // acc_second, acc_third, acc_complete, zero pad
  output logic [OUT_DATA_W-1:0]   out_tdata,
  output logic                    out_tuser    // item_kind
);

  logic   stg_v;
  logic   stg_ready;
  stg_t   stg;
  gains_t gains;

  nafd_frame_ctl u_frame_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .stg_ready (stg_ready),
    .stg_v     (stg_v),
    .stg       (stg),
    .gains     (gains)
  );

  nafd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .stg_v      (stg_v),
    .stg        (stg),
    .gains      (gains),
    .stg_ready  (stg_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/core/nafd_frame_ctl.sv
`default_nettype none

module nafd_frame_ctl import nafd_pkg::*; (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [WORD_W-1:0]      in_tdata,
  input  wire                    stg_ready,
  output logic                   stg_v,
  output stg_t                   stg,
  output gains_t                 gains
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CHIP_W-1:0] chip_r, chip_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic [WORD_W-1:0] stamp_lo_r, stamp_lo_nxt;
  logic [WORD_W-1:0] stamp_hi_r, stamp_hi_nxt;
  logic [WORD_W-1:0] digital_r, digital_nxt;
  logic [WORD_W-1:0] acc_r [3];
  logic [WORD_W-1:0] acc_nxt [3];
  logic [1:0]        phase_r, phase_nxt;
  logic              begun_r, begun_nxt;
  gains_t            gains_r, gains_nxt;
  logic              stg_v_r, stg_v_nxt;
  stg_t              stg_r, stg_nxt;
  logic              accept;
  logic              load;
  logic              in_amp;
  logic [31:0]       ch_full;

  assign in_tready = !stg_v_r || stg_ready;
  assign accept    = in_tvalid && in_tready;
  assign in_amp    = (pos_r >= POS_W'(POS_AMP0)) && (pos_r < POS_W'(POS_AMP0 + TOTAL_CH));
  assign ch_full   = 32'(chip_r) * 32'(CHANNELS_PER_CHIP) + 32'(chan_r);

  always_comb begin
    pos_nxt      = pos_r;
    chip_nxt     = chip_r;
    chan_nxt     = chan_r;
    stamp_lo_nxt = stamp_lo_r;
    stamp_hi_nxt = stamp_hi_r;
    digital_nxt  = digital_r;
    acc_nxt      = acc_r;
    phase_nxt    = phase_r;
    begun_nxt    = begun_r;
    gains_nxt    = gains_r;
    load         = 1'b0;
    stg_nxt      = stg_r;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_PHASE: begin
          phase_nxt = cfg_data[1:0];
          begun_nxt = (cfg_data[1:0] == PHASE_FIRST);
        end
        CFG_AMP_GAIN: gains_nxt.amp_gain = cfg_data[WORD_W-1:0];
        CFG_ACC_GAIN: gains_nxt.acc_gain = cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end

    if (accept) begin
      pos_nxt = (pos_r >= POS_W'(POS_LAST)) ? '0 : pos_r + 1'b1;
      if (pos_r == POS_W'(POS_STAMP_LO)) begin
        stamp_lo_nxt = in_tdata;
      end else if (pos_r == POS_W'(POS_STAMP_HI)) begin
        stamp_hi_nxt = in_tdata;
      end else if (pos_r == POS_W'(POS_ACC)) begin
        if (phase_r != PHASE_NONE && begun_r) begin
          acc_nxt[phase_r - PHASE_FIRST] = in_tdata;
        end
      end else if (in_amp) begin
        load         = 1'b1;
        stg_nxt      = '0;
        stg_nxt.kind = KIND_SAMPLE;
        stg_nxt.chan = ch_full[CHAN_IDX_W-1:0];
        stg_nxt.word = in_tdata;
        if (chip_r == CHIP_W'(CHIP_COUNT - 1)) begin
          chip_nxt = '0;
          chan_nxt = chan_r + 1'b1;
        end else begin
          chip_nxt = chip_r + 1'b1;
        end
      end else if (pos_r == POS_W'(POS_DIGITAL)) begin
        digital_nxt = in_tdata;
      end else if (pos_r == POS_W'(POS_LAST)) begin
        load            = 1'b1;
        stg_nxt         = '0;
        stg_nxt.kind    = KIND_SUMMARY;
        stg_nxt.stamp   = {stamp_hi_r, stamp_lo_r};
        stg_nxt.digital = digital_r;
        stg_nxt.acc0    = acc_r[0];
        stg_nxt.acc1    = acc_r[1];
        stg_nxt.acc2    = acc_r[2];
        stg_nxt.done    = begun_r && (phase_r == PHASE_LAST);
        phase_nxt       = phase_r + 1'b1;
        if (phase_nxt == PHASE_FIRST) begin
          begun_nxt = 1'b1;
        end
        chip_nxt = '0;
        chan_nxt = '0;
      end
    end

    if (load) begin
      stg_v_nxt = 1'b1;
    end else if (stg_ready) begin
      stg_v_nxt = 1'b0;
    end else begin
      stg_v_nxt = stg_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      chip_r     <= '0;
      chan_r     <= '0;
      stamp_lo_r <= '0;
      stamp_hi_r <= '0;
      digital_r  <= '0;
      acc_r[0]   <= ACC_WORD_RST;
      acc_r[1]   <= ACC_WORD_RST;
      acc_r[2]   <= ACC_WORD_RST;
      phase_r    <= PHASE_NONE;
      begun_r    <= 1'b0;
      gains_r    <= '{amp_gain: AMP_GAIN_RST, acc_gain: ACC_GAIN_RST};
      stg_v_r    <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      chip_r     <= chip_nxt;
      chan_r     <= chan_nxt;
      stamp_lo_r <= stamp_lo_nxt;
      stamp_hi_r <= stamp_hi_nxt;
      digital_r  <= digital_nxt;
      acc_r      <= acc_nxt;
      phase_r    <= phase_nxt;
      begun_r    <= begun_nxt;
      gains_r    <= gains_nxt;
      stg_v_r    <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign stg_v = stg_v_r;
  assign stg   = stg_r;
  assign gains = gains_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(POS_LAST))
    else $error("frame position beyond last word");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r && !stg_ready |=> stg_v_r && $stable(stg_r))
    else $error("stalled stage entry lost or changed");

  a_summary_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && pos_r == POS_W'(POS_LAST) && !cfg_we |=> pos_r == '0 && stg_v_r
      && stg_r.kind == KIND_SUMMARY)
    else $error("frame end did not issue summary and restart");

endmodule

`default_nettype wire

// File: rtl/core/nafd_out_stage.sv
`default_nettype none

module nafd_out_stage import nafd_pkg::*; (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     stg_v,
  input  stg_t                    stg,
  input  gains_t                  gains,
  output logic                    stg_ready,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,
  output logic                    out_tuser
);

  localparam int OFF_CH   = 0;
  localparam int OFF_AMP  = OFF_CH + CHAN_IDX_W;
  localparam int OFF_TS   = OFF_AMP + VAL_W;
  localparam int OFF_DIG  = OFF_TS + VAL_W;
  localparam int OFF_ACC1 = OFF_DIG + WORD_W;
  localparam int OFF_ACC2 = OFF_ACC1 + VAL_W;
  localparam int OFF_ACC3 = OFF_ACC2 + VAL_W;
  localparam int OFF_DONE = OFF_ACC3 + VAL_W;

  function automatic logic [VAL_W-1:0] scale_code(input logic [WORD_W-1:0] w,
                                                  input logic [WORD_W-1:0] g);
    logic signed [WORD_W:0]     c;
    logic signed [WORD_W:0]     gs;
    logic signed [2*WORD_W+1:0] p;
    c  = {~w[WORD_W-1], ~w[WORD_W-1], w[WORD_W-2:0]};
    gs = {1'b0, g};
    p  = c * gs;
    return p[VAL_W-1:0];
  endfunction

  logic                  out_v_r, out_v_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;
  logic                  load;
  logic                  summary;
  logic [VAL_W-1:0]      prod0, prod1, prod2;

  assign stg_ready = !out_v_r || out_tready;
  assign load      = stg_v && stg_ready;
  assign summary   = (stg.kind == KIND_SUMMARY);

  assign prod0 = scale_code(summary ? stg.acc0 : stg.word,
                            summary ? gains.acc_gain : gains.amp_gain);
  assign prod1 = scale_code(stg.acc1, gains.acc_gain);
  assign prod2 = scale_code(stg.acc2, gains.acc_gain);

  always_comb begin
    out_data_nxt = '0;
    out_user_nxt = stg.kind;
    case (stg.kind)
      KIND_SAMPLE: begin
        out_data_nxt[OFF_CH +: CHAN_IDX_W] = stg.chan;
        out_data_nxt[OFF_AMP +: VAL_W]     = prod0;
      end
      KIND_SUMMARY: begin
        out_data_nxt[OFF_TS +: VAL_W]   = stg.stamp;
        out_data_nxt[OFF_DIG +: WORD_W] = stg.digital;
        if (stg.done) begin
          out_data_nxt[OFF_ACC1 +: VAL_W] = prod0;
          out_data_nxt[OFF_ACC2 +: VAL_W] = prod1;
          out_data_nxt[OFF_ACC3 +: VAL_W] = prod2;
          out_data_nxt[OFF_DONE]          = 1'b1;
        end
      end
      default: ;
    endcase

    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_user_r == KIND_SAMPLE |-> out_data_r[OUT_DATA_W-1:OFF_TS] == '0)
    else $error("sample result carries summary fields");

  a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_user_r == KIND_SUMMARY |-> out_data_r[OFF_TS-1:0] == '0)
    else $error("summary result carries sample fields");

  a_acc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_data_r[OFF_DONE] |-> out_data_r[OFF_DONE-1:OFF_ACC1] == '0)
    else $error("accelerometer fields set without a complete triplet");

endmodule

`default_nettype wire

// File: test/neural_amp_frame_deframer_tb.sv
`timescale 1ns / 100ps

module neural_amp_frame_deframer_tb;
  import nafd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [1:0] PHASE_MID = 2'd2;
  localparam longint CODE_MID = 32768;
  localparam int FRAME_LEN = POS_LAST + 1;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    item_kind_t            kind;
    logic [CHAN_IDX_W-1:0] chan;
    logic [VAL_W-1:0]      amp;
    logic [VAL_W-1:0]      stamp;
    logic [WORD_W-1:0]     digital;
    logic [VAL_W-1:0]      acc1;
    logic [VAL_W-1:0]      acc2;
    logic [VAL_W-1:0]      acc3;
    logic                  done;
  } frame_result_t;

  class deframe_tracker;
    frame_result_t     due[$];
    int                errors;
    int                pos;
    logic [1:0]        phase;
    bit                begun;
    logic [WORD_W-1:0] amp_gain;
    logic [WORD_W-1:0] acc_gain;
    logic [WORD_W-1:0] stamp_lo;
    logic [WORD_W-1:0] stamp_hi;
    logic [WORD_W-1:0] digital;
    logic [WORD_W-1:0] acc_held [3];

    function new();
      errors = 0;
      pos = 0;
      phase = PHASE_NONE;
      begun = 1'b0;
      amp_gain = AMP_GAIN_RST;
      acc_gain = ACC_GAIN_RST;
      stamp_lo = '0;
      stamp_hi = '0;
      digital = '0;
      foreach (acc_held[i]) acc_held[i] = ACC_WORD_RST;
    endfunction

    function logic [VAL_W-1:0] scaled(logic [WORD_W-1:0] code, logic [WORD_W-1:0] gain);
      longint product;
      product = (longint'(code) - CODE_MID) * longint'(gain);
      return product[VAL_W-1:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_START_PHASE: begin
          phase = value[1:0];
          begun = (value[1:0] == PHASE_FIRST);
        end
        CFG_AMP_GAIN: amp_gain = value;
        CFG_ACC_GAIN: acc_gain = value;
        default: ;
      endcase
    endfunction

    function void take_word(logic [WORD_W-1:0] w);
      frame_result_t r;
      int k;
      r = '0;
      if (pos == POS_STAMP_LO) begin
        stamp_lo = w;
      end else if (pos == POS_STAMP_HI) begin
        stamp_hi = w;
      end else if (pos == POS_ACC) begin
        if (phase != PHASE_NONE && begun) acc_held[phase - 2'd1] = w;
      end else if (pos >= POS_AMP0 && pos < POS_AMP0 + TOTAL_CH) begin
        k = pos - POS_AMP0;
        r.kind = KIND_SAMPLE;
        r.chan = CHAN_IDX_W'((k % CHIP_COUNT) * CHANNELS_PER_CHIP + k / CHIP_COUNT);
        r.amp = scaled(w, amp_gain);
        due.push_back(r);
      end else if (pos == POS_DIGITAL) begin
        digital = w;
      end else if (pos == POS_LAST) begin
        r.kind = KIND_SUMMARY;
        r.stamp = {stamp_hi, stamp_lo};
        r.digital = digital;
        if (begun && phase == PHASE_LAST) begin
          r.acc1 = scaled(acc_held[0], acc_gain);
          r.acc2 = scaled(acc_held[1], acc_gain);
          r.acc3 = scaled(acc_held[2], acc_gain);
          r.done = 1'b1;
        end
        due.push_back(r);
        phase = phase + 2'd1;
        if (phase == PHASE_FIRST) begun = 1'b1;
      end
      pos = (pos >= POS_LAST) ? 0 : pos + 1;
    endfunction

    function void check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic user, logic [OUT_DATA_W-1:0] d);
      frame_result_t e;
      if (due.size() == 0) begin
        $error("result with nothing pending: kind %0b data %h", user, d);
        errors++;
        return;
      end
      e = due.pop_front();
      check_field("item_kind", e.kind, user);
      check_field("channel_index", e.chan, d[5:0]);
      check_field("amp_value", e.amp, d[37:6]);
      check_field("time_stamp", e.stamp, d[69:38]);
      check_field("digital_inputs", e.digital, d[85:70]);
      check_field("acc_first", e.acc1, d[117:86]);
      check_field("acc_second", e.acc2, d[149:118]);
      check_field("acc_third", e.acc3, d[181:150]);
      check_field("acc_complete", e.done, d[182]);
      check_field("pad", '0, d[183]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  deframe_tracker tracker = new();
  int send_idle = 0;
  int recv_stall = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet = 0;

  neural_amp_frame_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.match_result(out_tuser, out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      default: return WORD_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] corner_word(int p);
    if (p == POS_STAMP_HI) return 16'h8000;
    if (p == POS_ACC || p == POS_DIGITAL) return 16'hFFFF;
    if (p >= POS_AMP0 && p < POS_AMP0 + TOTAL_CH) begin
      case ((p - POS_AMP0) % 4)
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return 16'h8000;
        default: return 16'h7FFF;
      endcase
    end
    return 16'h0000;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    tracker.take_word(w);
  endtask

  task automatic wait_results_out();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.due.size() != 0);
  endtask

  task automatic drain();
    wait_results_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] index,
                         input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    tracker.write_reg(index, value);
  endtask

  task automatic configure(input logic [1:0] first_phase,
                           input logic [CFG_DATA_W-1:0] amp, acc);
    put_reg(CFG_START_PHASE, CFG_DATA_W'(first_phase));
    put_reg(CFG_AMP_GAIN, amp);
    put_reg(CFG_ACC_GAIN, acc);
    put_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(16'hFFFF)));
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_word(random_word());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < FRAME_LEN; p++) send_word(corner_word(p));
    drain();

    configure(PHASE_FIRST, 16'hFFFF, 16'hFFFF);
    for (int n = 0; n < 3 * FRAME_LEN; n++) begin
      if (n == 40) hold_requests <= hold_requests + 1;
      if (n == 150) wait_results_out();
      send_word(random_word());
    end
    drain();

    send_idle = 80;
    configure(PHASE_LAST, 16'h0000, 16'h0000);
    send_random(FRAME_LEN);
    drain();

    send_idle = 0;
    recv_stall = 80;
    configure(PHASE_MID, 16'h0001, 16'h0001);
    send_random(FRAME_LEN);
    drain();

    send_idle = 37;
    recv_stall = 37;
    configure(PHASE_NONE, CFG_DATA_W'($urandom_range(16'hFFFF)),
              CFG_DATA_W'($urandom_range(16'hFFFF)));
    send_random(FRAME_LEN);
    drain();

    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/nafd_pkg.sv
rtl/core/nafd_frame_ctl.sv
rtl/core/nafd_out_stage.sv
rtl/core/neural_amp_frame_deframer.sv
test/neural_amp_frame_deframer_tb.sv
